>>> hw/rtl/imd_pkg.sv
// ----------------------------------------------------------------------------
// imd_pkg
// Shared constants and types of the integer multiply / divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imd_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes
    localparam int FUNC_W = 3;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UDIV = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UREM = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SDIV = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SREM = 3'd4;

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } imd_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture a new item
        logic step;   // one shift-add / restoring step
        logic store;  // write the finished result to the output register
    } imd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last_step;  // the current step is the final one
    } imd_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/imd_datapath.sv
// ----------------------------------------------------------------------------
// imd_datapath
// Operand, accumulator and quotient registers with one shared step unit:
// shift-add for multiply, restoring subtract for divide.
// ----------------------------------------------------------------------------
`default_nettype none

module imd_datapath #(
    parameter int DATA_WIDTH = imd_pkg::DATA_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  imd_pkg::imd_cmd_t            cmd,
    output imd_pkg::imd_status_t         status,
    input  wire [imd_pkg::FUNC_W-1:0]    in_func,
    input  wire [DATA_WIDTH-1:0]         in_a,
    input  wire [DATA_WIDTH-1:0]         in_b,
    output logic [DATA_WIDTH-1:0]        result
);

    import imd_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [DATA_WIDTH-1:0] a_reg, a_next;      // multiplicand, or dividend / quotient
    logic [DATA_WIDTH-1:0] b_reg, b_next;      // multiplier or divisor
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;  // product or partial remainder
    logic                  neg_q_reg, neg_r_reg;
    logic [DATA_WIDTH-1:0] result_reg, result_next;

    logic                  in_signed;
    logic                  in_na, in_nb;
    logic [DATA_WIDTH-1:0] a_load, b_load;
    logic [DATA_WIDTH-1:0] shifted, diff, sum;
    logic                  carry, ge;

    // operand magnitudes for the signed forms
    always_comb
    begin
        in_signed = in_func inside {FUNC_SDIV, FUNC_SREM};
        in_na     = in_a[DATA_WIDTH-1];
        in_nb     = in_b[DATA_WIDTH-1];
        a_load    = (in_signed && in_na) ? ({DATA_WIDTH{1'b0}} - in_a) : in_a;
        b_load    = (in_signed && in_nb) ? ({DATA_WIDTH{1'b0}} - in_b) : in_b;
    end

    // shared step unit
    always_comb
    begin
        carry   = acc_reg[DATA_WIDTH-1];
        shifted = {acc_reg[DATA_WIDTH-2:0], a_reg[DATA_WIDTH-1]};
        diff    = shifted - b_reg;
        ge      = carry || (shifted >= b_reg);
        sum     = acc_reg + a_reg;

        if (func_reg == FUNC_MUL)
        begin
            acc_next = b_reg[0] ? sum : acc_reg;
            a_next   = {a_reg[DATA_WIDTH-2:0], 1'b0};
            b_next   = {1'b0, b_reg[DATA_WIDTH-1:1]};
        end
        else
        begin
            acc_next = ge ? diff : shifted;
            a_next   = {a_reg[DATA_WIDTH-2:0], ge};
            b_next   = b_reg;
        end
    end

    // final sign fix and result select
    always_comb
    begin
        case (func_reg)
            FUNC_MUL:  result_next = acc_reg;
            FUNC_UDIV: result_next = a_reg;
            FUNC_UREM: result_next = acc_reg;
            FUNC_SDIV: result_next = neg_q_reg ? ({DATA_WIDTH{1'b0}} - a_reg) : a_reg;
            FUNC_SREM: result_next = neg_r_reg ? ({DATA_WIDTH{1'b0}} - acc_reg) : acc_reg;
            default:   result_next = '0;
        endcase
    end

    // step counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
            cnt_next = CNT_W'(DATA_WIDTH - 1);
        else if (cmd.step)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_func;
            a_reg     <= a_load;
            b_reg     <= b_load;
            acc_reg   <= '0;
            neg_q_reg <= in_na ^ in_nb;
            neg_r_reg <= in_na;
        end
        else if (cmd.step)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            acc_reg <= acc_next;
        end
        if (cmd.store)
            result_reg <= result_next;
    end

    assign status.last_step = (cnt_reg == '0);
    assign result           = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/imd_ctrl.sv
// ----------------------------------------------------------------------------
// imd_ctrl
// Sequencer of the multiply / divide unit: takes an item, runs the step
// unit once per operand bit, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imd_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    output imd_pkg::imd_cmd_t     cmd,
    input  imd_pkg::imd_status_t  status
);

    import imd_pkg::*;

    imd_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.store      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/integer_mul_div_unit.sv
// Sequence: an accepted item is loaded, stepped once per operand bit, then stored in
//   the output register; the store waits only while a previous result is still waiting at the output.
// Occupancy: one item at a time; a new item is taken only once the current result is stored,
//   as the single shared step unit handles one operand bit per cycle.
// Reset: rst_n asynchronous, active low; clears controller state, step counter
//   and output valid. Data registers are not reset.
// ----------------------------------------------------------------------------
// integer_mul_div_unit
// DATA_WIDTH-bit (32 by default) integer unit: shift-add multiply and restoring divide / modulo,
// unsigned and signed, on a stream interface.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_mul_div_unit #(
    parameter int DATA_WIDTH = imd_pkg::DATA_WIDTH_DEF
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       s_axis_tvalid,
    output logic                                      s_axis_tready,
    // func[2:0], operand_a, operand_b, zero pad
    input  wire [((2*DATA_WIDTH+imd_pkg::FUNC_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire                                       m_axis_tready,
    // result, zero pad
    output logic [((DATA_WIDTH+7)/8)*8-1:0]           m_axis_tdata
);

    import imd_pkg::*;

    localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    imd_cmd_t              cmd;
    imd_status_t           status;
    logic [FUNC_W-1:0]     in_func;
    logic [DATA_WIDTH-1:0] in_a, in_b;
    logic [DATA_WIDTH-1:0] result;

    // unpack the input transfer
    assign in_func = s_axis_tdata[FUNC_W-1:0];
    assign in_a    = s_axis_tdata[FUNC_W +: DATA_WIDTH];
    assign in_b    = s_axis_tdata[FUNC_W + DATA_WIDTH +: DATA_WIDTH];

    imd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    imd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .in_func (in_func),
        .in_a    (in_a),
        .in_b    (in_b),
        .result  (result)
    );

    // pack the output transfer
    assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

`default_nettype wire

>>> hw/rtl/imd_checker.sv
// ----------------------------------------------------------------------------
// imd_checker
// Port-level checks of the multiply / divide unit over time.
// ----------------------------------------------------------------------------
`default_nettype none

module imd_checker #(
    parameter int DATA_WIDTH = imd_pkg::DATA_WIDTH_DEF
) (
    input wire                                              clk,
    input wire                                              rst_n,
    input wire                                              s_axis_tvalid,
    input wire                                              s_axis_tready,
    input wire                                              m_axis_tvalid,
    input wire                                              m_axis_tready,
    input wire [((DATA_WIDTH+7)/8)*8-1:0]                   m_axis_tdata
);

    // a waiting result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped before transfer");

    // a waiting result holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed before transfer");

    // the input is still not ready once the current item has run all its steps
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##(DATA_WIDTH + 1) !s_axis_tready)
        else $error("input taken while an item is still in progress");

    // a new result appears only out of the busy phase
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a finished item");

endmodule

bind integer_mul_div_unit imd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_imd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
